>>> rtl/cafp_pkg.sv
package cafp_pkg;

    // frame limits
    localparam logic [7:0] MAX_VALUE_BYTES = 8'd4;
    localparam logic [6:0] MAX_ENTRIES     = 7'd32;

    // queue between parser and result sequencer
    localparam int QDEPTH = 4;
    localparam int QAW    = 2;

    typedef enum logic [1:0] {
        KIND_HEADER = 2'd0,
        KIND_ENTRY  = 2'd1,
        KIND_END    = 2'd2
    } t_kind;

    typedef struct packed {
        logic [7:0] frame_byte;
        logic       is_last;
    } t_in_item;

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  op_code;
        logic [7:0]  persist_code;
        logic [5:0]  entry_count;
        logic        more_frames;
        logic [15:0] entry_id;
        logic [6:0]  param_status;
        logic        override_flag;
        logic [7:0]  ptype;
        logic [7:0]  value_len;
        logic [31:0] value_word;
        logic        frame_status;
    } t_out_item;

    // what one accepted byte leaves for the back end
    typedef struct packed {
        logic      main_valid;
        t_out_item main;
        logic      end_valid;
        logic      end_bad;
    } t_rec;

endpackage

>>> rtl/cafp_front.sv
module cafp_front import cafp_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_accept,
    input  t_in_item i_in_item,
    output logic     o_wr,
    output t_rec     o_rec
);

    typedef enum logic [2:0] {
        PH_OP, PH_PERSIST, PH_COUNT, PH_ID, PH_STATUS, PH_PTYPE, PH_LEN, PH_VALUE
    } t_phase;

    t_phase      r_phase,   n_phase;
    logic [7:0]  r_bif,     n_bif;
    logic [6:0]  r_left,    n_left;
    logic [7:0]  r_op,      n_op;
    logic [7:0]  r_persist, n_persist;
    logic [15:0] r_id,      n_id;
    logic [7:0]  r_status,  n_status;
    logic [7:0]  r_ptype,   n_ptype;
    logic [7:0]  r_len,     n_len;
    logic [31:0] r_val,     n_val;
    logic        r_error,   n_error;

    logic [7:0]  b;
    logic [8:0]  bif_inc;
    logic        emit;
    t_rec        rec;

    assign b = i_in_item.frame_byte;

    always_comb begin
        n_phase   = r_phase;
        n_bif     = r_bif;
        n_left    = r_left;
        n_op      = r_op;
        n_persist = r_persist;
        n_id      = r_id;
        n_status  = r_status;
        n_ptype   = r_ptype;
        n_len     = r_len;
        n_val     = r_val;
        n_error   = r_error;
        emit      = 1'b0;
        bif_inc   = {1'b0, r_bif} + 9'd1;
        rec       = '0;

        if (!r_error) begin
            unique case (r_phase)
                PH_OP: begin
                    n_op    = b;
                    n_phase = PH_PERSIST;
                end
                PH_PERSIST: begin
                    n_persist = b;
                    n_phase   = PH_COUNT;
                end
                PH_COUNT: begin
                    if (b[6:0] > MAX_ENTRIES) begin
                        n_error = 1'b1;
                    end else begin
                        rec.main_valid        = 1'b1;
                        rec.main.kind         = KIND_HEADER;
                        rec.main.op_code      = r_op;
                        rec.main.persist_code = r_persist;
                        rec.main.entry_count  = b[5:0];
                        rec.main.more_frames  = b[7];
                        n_left                = b[6:0];
                        n_phase               = PH_ID;
                        n_bif                 = '0;
                    end
                end
                PH_ID: begin
                    if (r_left == '0) begin
                        // trailing byte after the last entry
                        n_error = 1'b1;
                    end else if (r_bif == '0) begin
                        n_id  = {8'd0, b};
                        n_bif = 8'd1;
                    end else begin
                        n_id    = {b, r_id[7:0]};
                        n_bif   = '0;
                        n_phase = PH_STATUS;
                    end
                end
                PH_STATUS: begin
                    n_status = b;
                    n_phase  = PH_PTYPE;
                end
                PH_PTYPE: begin
                    n_ptype = b;
                    n_phase = PH_LEN;
                end
                PH_LEN: begin
                    n_len = b;
                    n_val = '0;
                    n_bif = '0;
                    if (b == '0) begin
                        emit = 1'b1;
                    end else begin
                        n_phase = PH_VALUE;
                    end
                end
                PH_VALUE: begin
                    if (r_len <= MAX_VALUE_BYTES && r_bif[7:2] == '0) begin
                        case (r_bif[1:0])
                            2'd0:    n_val = r_val | {24'd0, b};
                            2'd1:    n_val = r_val | {16'd0, b, 8'd0};
                            2'd2:    n_val = r_val | {8'd0, b, 16'd0};
                            default: n_val = r_val | {b, 24'd0};
                        endcase
                    end
                    n_bif = bif_inc[7:0];
                    if (bif_inc >= {1'b0, r_len}) begin
                        emit = 1'b1;
                    end
                end
                default: begin
                    n_phase = PH_OP;
                end
            endcase
        end

        if (emit) begin
            rec.main_valid         = 1'b1;
            rec.main.kind          = KIND_ENTRY;
            rec.main.entry_id      = r_id;
            rec.main.param_status  = r_status[6:0];
            rec.main.override_flag = r_status[7];
            rec.main.ptype         = r_ptype;
            rec.main.value_len     = n_len;
            rec.main.value_word    = (n_len <= MAX_VALUE_BYTES) ? n_val : '0;
            n_left                 = r_left - 7'd1;
            n_phase                = PH_ID;
            n_bif                  = '0;
        end

        if (i_in_item.is_last) begin
            rec.end_valid = 1'b1;
            rec.end_bad   = !(!n_error && n_phase == PH_ID && n_left == '0 && n_bif == '0);
            // frame done, back to awaiting a header
            n_phase   = PH_OP;
            n_bif     = '0;
            n_left    = '0;
            n_op      = '0;
            n_persist = '0;
            n_id      = '0;
            n_status  = '0;
            n_ptype   = '0;
            n_len     = '0;
            n_val     = '0;
            n_error   = 1'b0;
        end
    end

    assign o_rec = rec;
    assign o_wr  = i_accept && (rec.main_valid || rec.end_valid);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_OP;
            r_bif     <= '0;
            r_left    <= '0;
            r_op      <= '0;
            r_persist <= '0;
            r_id      <= '0;
            r_status  <= '0;
            r_ptype   <= '0;
            r_len     <= '0;
            r_val     <= '0;
            r_error   <= 1'b0;
        end else if (i_accept) begin
            r_phase   <= n_phase;
            r_bif     <= n_bif;
            r_left    <= n_left;
            r_op      <= n_op;
            r_persist <= n_persist;
            r_id      <= n_id;
            r_status  <= n_status;
            r_ptype   <= n_ptype;
            r_len     <= n_len;
            r_val     <= n_val;
            r_error   <= n_error;
        end
    end

endmodule

>>> rtl/cafp_fifo.sv
module cafp_fifo import cafp_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_wr,
    input  t_rec i_wdata,
    input  logic i_rd,
    output t_rec o_rdata,
    output logic o_full,
    output logic o_empty
);

    t_rec           r_mem [QDEPTH];
    logic [QAW-1:0] r_wptr;
    logic [QAW-1:0] r_rptr;
    logic [QAW:0]   r_count;
    logic           do_wr;
    logic           do_rd;

    assign o_full  = (r_count == (QAW+1)'(QDEPTH));
    assign o_empty = (r_count == '0);
    assign do_wr   = i_wr && !o_full;
    assign do_rd   = i_rd && !o_empty;
    assign o_rdata = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (do_wr) begin
            r_mem[r_wptr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (do_wr) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (do_rd) begin
                r_rptr <= r_rptr + 1'b1;
            end
            case ({do_wr, do_rd})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

>>> rtl/cafp_back.sv
module cafp_back import cafp_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_rec      i_rec,
    input  logic      i_rec_empty,
    output logic      o_rec_rd,
    input  logic      i_pop,
    output logic      o_empty,
    output t_out_item o_out_item
);

    logic      r_valid;
    logic      r_main_done;
    t_rec      r_rec;
    logic      show_main;
    logic      finish;
    logic      load;
    t_out_item end_item;

    assign show_main = r_rec.main_valid && !r_main_done;
    assign finish    = i_pop && r_valid && (!show_main || !r_rec.end_valid);
    assign load      = !r_valid || finish;
    assign o_rec_rd  = load && !i_rec_empty;
    assign o_empty   = !r_valid;

    always_comb begin
        end_item              = '0;
        end_item.kind         = KIND_END;
        end_item.frame_status = r_rec.end_bad;
    end

    assign o_out_item = show_main ? r_rec.main : end_item;

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_rec <= i_rec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid     <= 1'b0;
            r_main_done <= 1'b0;
        end else if (load) begin
            r_valid     <= !i_rec_empty;
            r_main_done <= 1'b0;
        end else if (i_pop && show_main) begin
            // header or entry taken, end status still to go
            r_main_done <= 1'b1;
        end
    end

endmodule

>>> rtl/config_ack_frame_parser.sv
// path: a result item goes through the queue and the sequencer's record register to the output
// throughput: one frame byte per cycle while the queue is not full; the result side delivers one
//   item per cycle while pop is high, and a last byte that also closes an entry or header yields two items
// a four-record queue between the byte parser and the result sequencer absorbs pop stalls
// reset (synchronous, active low): parser awaits an op byte, queue and output are empty
module config_ack_frame_parser import cafp_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      push,
    input  t_in_item  i_in_item,
    output logic      full,
    output logic      empty,
    input  logic      pop,
    output t_out_item o_out_item
);

    // front end: byte parser, one record per accepted byte that yields anything
    logic accept;
    logic rec_wr;
    t_rec rec_w;

    // queue between parser and sequencer
    t_rec rec_r;
    logic rec_rd;
    logic q_empty;

    // the parser only stalls on a full queue
    assign accept = push && !full;

    cafp_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (accept),
        .i_in_item (i_in_item),
        .o_wr      (rec_wr),
        .o_rec     (rec_w)
    );

    cafp_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (rec_wr),
        .i_wdata (rec_w),
        .i_rd    (rec_rd),
        .o_rdata (rec_r),
        .o_full  (full),
        .o_empty (q_empty)
    );

    // back end: splits a record into its header/entry item and its end status item
    cafp_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rec       (rec_r),
        .i_rec_empty (q_empty),
        .o_rec_rd    (rec_rd),
        .i_pop       (pop),
        .o_empty     (empty),
        .o_out_item  (o_out_item)
    );

endmodule

>>> verif/tb_config_ack_frame_parser.sv
module tb_config_ack_frame_parser;
    import cafp_pkg::*;

    // run limit in clock cycles, several times the slowest legal run
    localparam int CYCLE_LIMIT   = 600000;
    localparam int RANDOM_BYTES  = 540;
    localparam int MAX_WAIT      = 16;
    localparam int HOLD_CYCLES   = 250;
    localparam int SETTLE_CYCLES = 8;

    // parser phases as the predictor tracks them
    typedef enum logic [2:0] {
        P_OPCODE  = 3'd0,
        P_PERSIST = 3'd1,
        P_COUNT   = 3'd2,
        P_ID      = 3'd3,
        P_STATUS  = 3'd4,
        P_PTYPE   = 3'd5,
        P_LEN     = 3'd6,
        P_VALUE   = 3'd7
    } t_parse_phase;

    // shapes of generated frames
    typedef enum int {
        FR_GOOD,
        FR_SHORT,
        FR_TRAIL,
        FR_OVERCOUNT,
        FR_NOISE
    } t_frame_shape;

    logic      i_clk   = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      push    = 1'b0;
    t_in_item  i_in_item = '0;
    logic      pop     = 1'b0;
    logic      full;
    logic      empty;
    t_out_item o_out_item;

    config_ack_frame_parser uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .push       (push),
        .i_in_item  (i_in_item),
        .full       (full),
        .empty      (empty),
        .pop        (pop),
        .o_out_item (o_out_item)
    );

    always #10 i_clk = ~i_clk;

    // results predicted but not yet seen on the output
    t_out_item pending_results[$];
    // bytes of the frame being sent
    logic [7:0] frame_bytes[$];

    int mismatches  = 0;
    int bytes_sent  = 0;
    int cycle_count = 0;
    // random waits on both sides are on while this is set
    logic idle_on = 1'b1;
    // a nonzero value makes the result side hold off that many cycles
    int hold_len = 0;

    // predictor copy of the parser state
    t_parse_phase pm_phase;
    logic [7:0]   pm_bif;
    logic [6:0]   pm_left;
    logic [7:0]   pm_op;
    logic [7:0]   pm_persist;
    logic [15:0]  pm_id;
    logic [7:0]   pm_status;
    logic [7:0]   pm_ptype;
    logic [7:0]   pm_len;
    logic [31:0]  pm_value;
    logic         pm_err;

    // run guard
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic parser_model_clear();
        pm_phase   = P_OPCODE;
        pm_bif     = '0;
        pm_left    = '0;
        pm_op      = '0;
        pm_persist = '0;
        pm_id      = '0;
        pm_status  = '0;
        pm_ptype   = '0;
        pm_len     = '0;
        pm_value   = '0;
        pm_err     = 1'b0;
    endtask

    // entry result from the collected fields, then back to the next id
    task automatic close_entry(output t_out_item r);
        r               = '0;
        r.kind          = KIND_ENTRY;
        r.entry_id      = pm_id;
        r.param_status  = pm_status[6:0];
        r.override_flag = pm_status[7];
        r.ptype         = pm_ptype;
        r.value_len     = pm_len;
        // an over-long value is skipped and reported as zero
        r.value_word    = (pm_len <= MAX_VALUE_BYTES) ? pm_value : 32'h0;
        pm_left         = pm_left - 7'd1;
        pm_phase        = P_ID;
        pm_bif          = '0;
    endtask

    // expected results for one accepted frame byte
    task automatic predict_parse(input logic [7:0] b, input logic last);
        t_out_item main;
        t_out_item fin;
        logic      emitted;
        logic      ok;
        main    = '0;
        emitted = 1'b0;
        if (!pm_err) begin
            case (pm_phase)
                P_OPCODE: begin
                    pm_op    = b;
                    pm_phase = P_PERSIST;
                end
                P_PERSIST: begin
                    pm_persist = b;
                    pm_phase   = P_COUNT;
                end
                P_COUNT: begin
                    // count over the maximum: no header, rest of frame ignored
                    if (b[6:0] > MAX_ENTRIES) begin
                        pm_err = 1'b1;
                    end else begin
                        main.kind         = KIND_HEADER;
                        main.op_code      = pm_op;
                        main.persist_code = pm_persist;
                        main.entry_count  = b[5:0];
                        main.more_frames  = b[7];
                        emitted           = 1'b1;
                        pm_left           = b[6:0];
                        pm_phase          = P_ID;
                        pm_bif            = '0;
                    end
                end
                P_ID: begin
                    // byte after the last entry marks the frame bad
                    if (pm_left == 0) begin
                        pm_err = 1'b1;
                    end else if (pm_bif == 0) begin
                        pm_id  = {8'h00, b};
                        pm_bif = 8'd1;
                    end else begin
                        pm_id[15:8] = b;
                        pm_bif      = '0;
                        pm_phase    = P_STATUS;
                    end
                end
                P_STATUS: begin
                    pm_status = b;
                    pm_phase  = P_PTYPE;
                end
                P_PTYPE: begin
                    pm_ptype = b;
                    pm_phase = P_LEN;
                end
                P_LEN: begin
                    pm_len   = b;
                    pm_value = '0;
                    pm_bif   = '0;
                    if (b == 0) begin
                        close_entry(main);
                        emitted = 1'b1;
                    end else begin
                        pm_phase = P_VALUE;
                    end
                end
                default: begin
                    if (pm_len <= MAX_VALUE_BYTES && pm_bif < 8'd4)
                        pm_value = pm_value | ({24'h0, b} << (8 * pm_bif));
                    pm_bif = pm_bif + 8'd1;
                    if (pm_bif >= pm_len) begin
                        close_entry(main);
                        emitted = 1'b1;
                    end
                end
            endcase
        end
        if (emitted)
            pending_results.push_back(main);
        // end status comes after any other result of the last byte
        if (last) begin
            ok = !pm_err && pm_phase == P_ID && pm_left == 0 && pm_bif == 0;
            fin              = '0;
            fin.kind         = KIND_END;
            fin.frame_status = !ok;
            pending_results.push_back(fin);
            parser_model_clear();
        end
    endtask

    // offer one byte after a random gap, return once it is taken
    task automatic send_byte(input logic [7:0] b, input logic last);
        int gap;
        gap = idle_on ? $urandom_range(0, MAX_WAIT) : 0;
        if (gap != 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        push                 <= 1'b1;
        i_in_item.frame_byte <= b;
        i_in_item.is_last    <= last;
        do @(posedge i_clk); while (full);
        predict_parse(b, last);
        bytes_sent++;
    endtask

    task automatic send_frame_bytes();
        for (int i = 0; i < frame_bytes.size(); i++)
            send_byte(frame_bytes[i], i == frame_bytes.size() - 1);
    endtask

    function automatic logic [7:0] rand_byte();
        return 8'($urandom_range(0, 255));
    endfunction

    // build a frame of the given shape with random content and send it
    task automatic send_frame(input int n_ent, input t_frame_shape shape);
        int pick;
        int vlen;
        int cut;
        frame_bytes.delete();
        if (shape == FR_NOISE) begin
            repeat ($urandom_range(1, 12)) frame_bytes.push_back(rand_byte());
        end else begin
            frame_bytes.push_back(rand_byte());
            frame_bytes.push_back(rand_byte());
            if (shape == FR_OVERCOUNT) begin
                frame_bytes.push_back({1'($urandom_range(0, 1)),
                                       7'($urandom_range(33, 127))});
                repeat ($urandom_range(0, 8)) frame_bytes.push_back(rand_byte());
            end else begin
                frame_bytes.push_back({1'($urandom_range(0, 1)), 7'(n_ent)});
                for (int e = 0; e < n_ent; e++) begin
                    frame_bytes.push_back(rand_byte());
                    frame_bytes.push_back(rand_byte());
                    frame_bytes.push_back(rand_byte());
                    frame_bytes.push_back(rand_byte());
                    // mostly short values, some skipped, rarely very long
                    pick = $urandom_range(0, 99);
                    if (pick < 70)
                        vlen = $urandom_range(0, 4);
                    else if (pick < 95)
                        vlen = $urandom_range(5, 12);
                    else if (pick < 99)
                        vlen = $urandom_range(13, 40);
                    else
                        vlen = $urandom_range(241, 255);
                    frame_bytes.push_back(8'(vlen));
                    repeat (vlen) frame_bytes.push_back(rand_byte());
                end
                if (shape == FR_SHORT) begin
                    cut = $urandom_range(1, frame_bytes.size() - 1);
                    while (frame_bytes.size() > cut) void'(frame_bytes.pop_back());
                end else if (shape == FR_TRAIL) begin
                    repeat ($urandom_range(1, 3)) frame_bytes.push_back(rand_byte());
                end
            end
        end
        send_frame_bytes();
    endtask

    // sender stops and waits for every predicted result
    task automatic wait_drain();
        push <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic check_field(input string name, input logic [31:0] exp,
                               input logic [31:0] act);
        if (exp !== act) begin
            $error("%s: expected %0h, got %0h", name, exp, act);
            mismatches++;
        end
    endtask

    task automatic check_result(input t_out_item got);
        t_out_item want;
        if (pending_results.size() == 0) begin
            $error("result item with no prediction waiting: %0h", got);
            mismatches++;
        end else begin
            want = pending_results.pop_front();
            check_field("kind", want.kind, got.kind);
            check_field("op_code", want.op_code, got.op_code);
            check_field("persist_code", want.persist_code, got.persist_code);
            check_field("entry_count", want.entry_count, got.entry_count);
            check_field("more_frames", want.more_frames, got.more_frames);
            check_field("entry_id", want.entry_id, got.entry_id);
            check_field("param_status", want.param_status, got.param_status);
            check_field("override_flag", want.override_flag, got.override_flag);
            check_field("ptype", want.ptype, got.ptype);
            check_field("value_len", want.value_len, got.value_len);
            check_field("value_word", want.value_word, got.value_word);
            check_field("frame_status", want.frame_status, got.frame_status);
        end
    endtask

    // result side: random stall per item, long hold-off on request
    initial begin
        int stall;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (hold_len != 0) begin
                pop <= 1'b0;
                repeat (hold_len) @(posedge i_clk);
                hold_len = 0;
            end
            stall = idle_on ? $urandom_range(0, MAX_WAIT) : 0;
            if (stall != 0) begin
                pop <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            pop <= 1'b1;
            // pop stays high until an item goes or a hold-off is asked for
            do @(posedge i_clk); while (empty && hold_len == 0);
            if (!empty)
                check_result(o_out_item);
        end
    end

    // header extremes, bad count, short and trailing frames, skipped value
    task automatic test_directed_frames();
        idle_on = 1'b1;
        // count of 32 with more-follows, but frame ends at the count byte
        frame_bytes = '{8'hFF, 8'hFF, 8'hA0};
        send_frame_bytes();
        // count one above the maximum, no header
        frame_bytes = '{8'h12, 8'h34, 8'h21};
        send_frame_bytes();
        // frame cut off at its first byte
        frame_bytes = '{8'h55};
        send_frame_bytes();
        // one entry with all-ones fields, last byte also ends the entry
        frame_bytes = '{8'h01, 8'h02, 8'h81, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
                        8'h04, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
        send_frame_bytes();
        // all-zero entry with a skipped five-byte value, then a trailing byte
        frame_bytes = '{8'h00, 8'h00, 8'h01, 8'h00, 8'h00, 8'h00, 8'h00,
                        8'h05, 8'h01, 8'h02, 8'h03, 8'h04, 8'h05, 8'h77};
        send_frame_bytes();
    endtask

    // hold the result side while the sender streams a long frame
    task automatic test_backpressure();
        idle_on  = 1'b0;
        hold_len = HOLD_CYCLES;
        send_frame(12, FR_GOOD);
        idle_on  = 1'b1;
    endtask

    // random frames, mostly well formed, until the byte budget is spent
    task automatic test_random_frames();
        int start;
        int pick;
        int n_ent;
        start = bytes_sent;
        // one frame with the largest entry count
        send_frame(int'(MAX_ENTRIES), FR_GOOD);
        while (bytes_sent - start < RANDOM_BYTES) begin
            idle_on = ($urandom_range(0, 3) != 0);
            n_ent   = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 12)
                                                  : $urandom_range(0, 4);
            pick    = $urandom_range(0, 99);
            if (pick < 72)
                send_frame(n_ent, FR_GOOD);
            else if (pick < 82)
                send_frame(n_ent, FR_SHORT);
            else if (pick < 88)
                send_frame(n_ent, FR_TRAIL);
            else if (pick < 94)
                send_frame(n_ent, FR_OVERCOUNT);
            else
                send_frame(n_ent, FR_NOISE);
            if ($urandom_range(0, 19) == 0)
                wait_drain();
        end
        idle_on = 1'b1;
    endtask

    initial begin
        parser_model_clear();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed_frames();
        wait_drain();
        test_backpressure();
        wait_drain();
        test_random_frames();
        wait_drain();
        // anything left in the block would show up as an unexpected item
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

>>> files.f
rtl/cafp_pkg.sv
rtl/cafp_front.sv
rtl/cafp_fifo.sv
rtl/cafp_back.sv
rtl/config_ack_frame_parser.sv
verif/tb_config_ack_frame_parser.sv
